[rtl/normalized_life_curve_macros.svh]
// Assertion helpers used by the checker file.
`ifndef NORMALIZED_LIFE_CURVE_MACROS_SVH
`define NORMALIZED_LIFE_CURVE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define NLC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nlc check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define NLC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nlc check failed");

`endif

[rtl/nlc_pkg.sv]
`timescale 1ns / 1ps

package nlc_pkg;

    // Command codes
    localparam logic [1:0] CMD_ROW     = 2'd0;
    localparam logic [1:0] CMD_SCALE   = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OVF = 2'd1;
    localparam logic [1:0] ST_FEW = 2'd2;

    // Configuration register indexes
    localparam logic CFG_TARGET_DIM = 1'b0;
    localparam logic CFG_EVAL_MODE  = 1'b1;

    // Field widths
    localparam int VAL_W   = 32;
    localparam int SUM_W   = 48;
    localparam int ACC_W   = 64;
    localparam int CURVE_W = 40;
    localparam int PIDX_W  = 6;
    localparam int DIM_W   = 3;
    localparam int NUM_W   = 64;
    localparam int DEN_W   = 48;
    localparam int DCNT_W  = 7;

    localparam logic [CURVE_W-1:0] CURVE_MAX = {CURVE_W{1'b1}};

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } t_div_rsp;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_POINT,
        S_SCALE,
        S_READ,
        S_PAIR,
        S_NDIV,
        S_MUL,
        S_ACC,
        S_NEXT,
        S_WDIV,
        S_EMIT
    } t_state;

endpackage

[rtl/nlc_pair_mem.sv]
`timescale 1ns / 1ps

module nlc_pair_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [nlc_pkg::VAL_W-1:0]     i_birth,
    input  logic [nlc_pkg::VAL_W-1:0]     i_death,
    input  logic [AW-1:0]                 i_raddr,
    output logic [nlc_pkg::VAL_W-1:0]     o_birth,
    output logic [nlc_pkg::VAL_W-1:0]     o_death
);

    logic [2*nlc_pkg::VAL_W-1:0] r_mem [DEPTH];
    logic [2*nlc_pkg::VAL_W-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_birth, i_death};
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_birth = r_rdata[2*nlc_pkg::VAL_W-1:nlc_pkg::VAL_W];
    assign o_death = r_rdata[nlc_pkg::VAL_W-1:0];

endmodule

[rtl/nlc_scale_mem.sv]
`timescale 1ns / 1ps

module nlc_scale_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [nlc_pkg::VAL_W-1:0]     i_wdata,
    input  logic [AW-1:0]                 i_raddr0,
    input  logic [AW-1:0]                 i_raddr1,
    output logic [nlc_pkg::VAL_W-1:0]     o_rdata0,
    output logic [nlc_pkg::VAL_W-1:0]     o_rdata1
);

    logic [nlc_pkg::VAL_W-1:0] r_mem [DEPTH];

    // One write port, two registered read ports (interval ends)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

[rtl/nlc_div.sv]
`timescale 1ns / 1ps

module nlc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nlc_pkg::t_div_req i_req,
    output nlc_pkg::t_div_rsp o_rsp
);

    localparam int NW = nlc_pkg::NUM_W;
    localparam int DW = nlc_pkg::DEN_W;

    logic [nlc_pkg::DCNT_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [NW-1:0]              r_num;
    logic [DW-1:0]              r_den;
    logic [DW:0]                r_rem;
    logic [DW:0]                rem_sh;
    logic [DW+1:0]              diff;

    // Restoring step: one quotient bit per cycle
    assign rem_sh = {r_rem[DW-1:0], r_num[NW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= nlc_pkg::DCNT_W'(NW);
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (!diff[DW+1]) begin
                    r_rem <= diff[DW:0];
                    r_num <= {r_num[NW-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_num <= {r_num[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == nlc_pkg::DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;

endmodule

[rtl/normalized_life_curve.sv]
`timescale 1ns / 1ps

// Normalized life curve of a persistence diagram.
// Input channel: a command beat is taken on a rising edge with i_start high
// and o_busy low. Command row loads a (birth, death) pair when its dimension
// matches the target and death is finite; command scale loads a scale point;
// compute emits the curve and then empties both stores.
// Row and scale beats leave the block idle and ready for the next beat.
// Compute holds o_busy high until the last result. Per result point it walks
// all stored pairs, unless intervals mode finds a width that is not positive;
// a contributing pair runs the shared radix-2 divider (64 steps) to form the
// normalized lifetime, and a skipped pair does not. In intervals mode, an
// interval with a positive sum adds a divide by the interval width.
// Results: o_valid strobes for one cycle per value with o_curve_value,
// o_point_index, o_last and o_status; the receiver cannot stall them.
// Configuration writes (i_cfg_we) take effect at once and belong to idle.
// Reset (synchronous, active low) clears counts, the lifetime sum, the overflow
// flag, the configuration, the state and o_valid; store contents stay undefined.
module normalized_life_curve #(
    parameter int DIAGRAM_DEPTH = 256,
    parameter int SCALE_DEPTH   = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_index,
    input  logic [nlc_pkg::DIM_W-1:0]       i_cfg_data,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [1:0]                      i_command,
    input  logic [nlc_pkg::DIM_W-1:0]       i_row_dimension,
    input  logic signed [nlc_pkg::VAL_W-1:0] i_birth_value,
    input  logic signed [nlc_pkg::VAL_W-1:0] i_death_value,
    input  logic                            i_death_infinite,
    input  logic signed [nlc_pkg::VAL_W-1:0] i_scale_value,
    output logic                            o_valid,
    output logic [nlc_pkg::CURVE_W-1:0]     o_curve_value,
    output logic [nlc_pkg::PIDX_W-1:0]      o_point_index,
    output logic                            o_last,
    output logic [1:0]                      o_status
);

    localparam int PAW = (DIAGRAM_DEPTH > 1) ? $clog2(DIAGRAM_DEPTH) : 1;
    localparam int PCW = $clog2(DIAGRAM_DEPTH + 1);
    localparam int SAW = $clog2(SCALE_DEPTH);
    localparam int SCW = $clog2(SCALE_DEPTH + 1);
    localparam int VW  = nlc_pkg::VAL_W;
    localparam int SW  = nlc_pkg::SUM_W;
    localparam int AW  = nlc_pkg::ACC_W;
    localparam int CW  = nlc_pkg::CURVE_W;

    nlc_pkg::t_state r_state, n_state;

    // Configuration
    logic [nlc_pkg::DIM_W-1:0] r_target_dim;
    logic                      r_eval_mode;

    // Load state
    logic [PCW-1:0]        r_pair_count;
    logic [SCW-1:0]        r_scale_count;
    logic signed [SW-1:0]  r_sum;
    logic                  r_ovf;

    // Compute state
    logic [SAW-1:0]        r_k;
    logic [SCW-1:0]        r_nres;
    logic [1:0]            r_status;
    logic [PCW-1:0]        r_pair_idx;
    logic signed [VW-1:0]  r_lo;
    logic signed [VW-1:0]  r_hi;
    logic [VW-1:0]         r_w;
    logic [VW-1:0]         r_c;
    logic                  r_neg;
    logic signed [VW-1:0]  r_n;
    logic signed [AW-1:0]  r_add;
    logic signed [AW-1:0]  r_acc;
    logic [CW-1:0]         r_value;

    // Result registers
    logic                      r_out_valid;
    logic [CW-1:0]             r_out_value;
    logic [nlc_pkg::PIDX_W-1:0] r_out_idx;
    logic                      r_out_last;
    logic [1:0]                r_out_status;

    // Memory and divider hookup
    logic                  accept;
    logic                  row_keep;
    logic                  pair_we;
    logic                  scale_we;
    logic [SAW-1:0]        scale_raddr1;
    logic signed [VW-1:0]  mem_b;
    logic signed [VW-1:0]  mem_d;
    logic signed [VW-1:0]  mem_s0;
    logic signed [VW-1:0]  mem_s1;
    nlc_pkg::t_div_req     div_req;
    nlc_pkg::t_div_rsp     div_rsp;

    // Per-pair arithmetic
    logic signed [VW:0]    life;
    logic [VW:0]           life_mag;
    logic [SW-1:0]         sum_mag;
    logic signed [VW-1:0]  top;
    logic signed [VW-1:0]  bot;
    logic signed [VW:0]    clip;
    logic                  alive;
    logic                  pair_use;
    logic signed [VW:0]    w_now;
    logic                  w_bad;
    logic signed [SW:0]    sum_next;
    logic signed [AW:0]    prod;
    logic signed [AW-1:0]  acc_sum;
    logic                  acc_ovf;
    logic signed [VW-1:0]  n_sat;
    logic [CW-1:0]         q_clamp;
    logic [CW-1:0]         acc_clamp;
    logic                  last_pt;
    logic                  pairs_done;

    assign accept = i_start && !o_busy;
    assign o_busy = (r_state != nlc_pkg::S_IDLE);

    assign row_keep = (i_row_dimension == r_target_dim) && !i_death_infinite;
    assign pair_we  = accept && (i_command == nlc_pkg::CMD_ROW) && row_keep
                      && (r_pair_count != PCW'(DIAGRAM_DEPTH));
    assign scale_we = accept && (i_command == nlc_pkg::CMD_SCALE)
                      && (r_scale_count != SCW'(SCALE_DEPTH));

    assign scale_raddr1 = (SCW'(r_k) + 1'b1 < SCW'(SCALE_DEPTH)) ?
                          SAW'(SCW'(r_k) + 1'b1) : r_k;

    nlc_pair_mem #(
        .DEPTH (DIAGRAM_DEPTH),
        .AW    (PAW)
    ) u_pair_mem (
        .i_clk   (i_clk),
        .i_we    (pair_we),
        .i_waddr (r_pair_count[PAW-1:0]),
        .i_birth (i_birth_value),
        .i_death (i_death_value),
        .i_raddr (r_pair_idx[PAW-1:0]),
        .o_birth (mem_b),
        .o_death (mem_d)
    );

    nlc_scale_mem #(
        .DEPTH (SCALE_DEPTH),
        .AW    (SAW)
    ) u_scale_mem (
        .i_clk    (i_clk),
        .i_we     (scale_we),
        .i_waddr  (r_scale_count[SAW-1:0]),
        .i_wdata  (i_scale_value),
        .i_raddr0 (r_k),
        .i_raddr1 (scale_raddr1),
        .o_rdata0 (mem_s0),
        .o_rdata1 (mem_s1)
    );

    nlc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Lifetime sum, saturating to 48 bits
    assign life     = {i_death_value[VW-1], i_death_value}
                      - {i_birth_value[VW-1], i_birth_value};
    assign sum_next = {r_sum[SW-1], r_sum} + {{(SW-VW){life[VW]}}, life};

    // Pair terms from the store read
    logic signed [VW:0] pl;
    assign pl       = {mem_d[VW-1], mem_d} - {mem_b[VW-1], mem_b};
    assign life_mag = pl[VW] ? -pl : pl;
    assign sum_mag  = r_sum[SW-1] ? -r_sum : r_sum;
    assign top      = (mem_d < r_hi) ? mem_d : r_hi;
    assign bot      = (mem_b > r_lo) ? mem_b : r_lo;
    assign clip     = {top[VW-1], top} - {bot[VW-1], bot};
    assign alive    = (r_lo >= mem_b) && (r_lo < mem_d);
    assign pair_use = (r_sum != '0) &&
                      (r_eval_mode ? alive : (!clip[VW] && (clip != '0)));

    // Interval width from the scale read
    assign w_now = {mem_s1[VW-1], mem_s1} - {mem_s0[VW-1], mem_s0};
    assign w_bad = w_now[VW] || (w_now == '0);

    // Normalized lifetime saturated to Q16.16
    always_comb begin
        if (r_neg) begin
            if (div_rsp.quot > AW'(64'h8000_0000)) begin
                n_sat = {1'b1, {(VW-1){1'b0}}};
            end else begin
                n_sat = -$signed(div_rsp.quot[VW-1:0]);
            end
        end else begin
            if (div_rsp.quot > AW'(64'h7FFF_FFFF)) begin
                n_sat = {1'b0, {(VW-1){1'b1}}};
            end else begin
                n_sat = $signed(div_rsp.quot[VW-1:0]);
            end
        end
    end

    // Weighted term and saturating accumulate
    assign prod    = r_n * $signed({1'b0, r_c});
    assign acc_sum = r_acc + r_add;
    assign acc_ovf = (r_acc[AW-1] == r_add[AW-1]) && (acc_sum[AW-1] != r_acc[AW-1]);

    // Curve clamps
    assign q_clamp   = (div_rsp.quot > AW'(nlc_pkg::CURVE_MAX)) ?
                       nlc_pkg::CURVE_MAX : div_rsp.quot[CW-1:0];
    assign acc_clamp = r_acc[AW-1] ? '0 :
                       ((r_acc > $signed(AW'(nlc_pkg::CURVE_MAX))) ?
                        nlc_pkg::CURVE_MAX : r_acc[CW-1:0]);

    assign last_pt    = (r_nres == '0) || (SCW'(r_k) + 1'b1 == r_nres);
    assign pairs_done = (r_pair_idx == r_pair_count);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nlc_pkg::S_IDLE: begin
                if (accept && i_command == nlc_pkg::CMD_COMPUTE) begin
                    n_state = nlc_pkg::S_CHECK;
                end
            end
            nlc_pkg::S_CHECK: begin
                n_state = (r_nres == '0) ? nlc_pkg::S_EMIT : nlc_pkg::S_POINT;
            end
            nlc_pkg::S_POINT: n_state = nlc_pkg::S_SCALE;
            nlc_pkg::S_SCALE: begin
                if (r_pair_count == '0 || (!r_eval_mode && w_bad)) begin
                    n_state = nlc_pkg::S_EMIT;
                end else begin
                    n_state = nlc_pkg::S_READ;
                end
            end
            nlc_pkg::S_READ: n_state = nlc_pkg::S_PAIR;
            nlc_pkg::S_PAIR: n_state = pair_use ? nlc_pkg::S_NDIV : nlc_pkg::S_NEXT;
            nlc_pkg::S_NDIV: begin
                if (div_rsp.done) begin
                    n_state = nlc_pkg::S_MUL;
                end
            end
            nlc_pkg::S_MUL: n_state = nlc_pkg::S_ACC;
            nlc_pkg::S_ACC: n_state = nlc_pkg::S_NEXT;
            nlc_pkg::S_NEXT: begin
                if (!pairs_done) begin
                    n_state = nlc_pkg::S_READ;
                end else if (r_eval_mode || r_acc[AW-1] || r_acc == '0) begin
                    n_state = nlc_pkg::S_EMIT;
                end else begin
                    n_state = nlc_pkg::S_WDIV;
                end
            end
            nlc_pkg::S_WDIV: begin
                if (div_rsp.done) begin
                    n_state = nlc_pkg::S_EMIT;
                end
            end
            nlc_pkg::S_EMIT: n_state = last_pt ? nlc_pkg::S_IDLE : nlc_pkg::S_POINT;
            default: n_state = nlc_pkg::S_IDLE;
        endcase
    end

    // Divider requests
    always_comb begin
        div_req = '0;
        unique case (r_state)
            nlc_pkg::S_PAIR: begin
                div_req.start = pair_use;
                div_req.num   = {{(AW-VW-17){1'b0}}, life_mag, 16'b0};
                div_req.den   = sum_mag;
            end
            nlc_pkg::S_NEXT: begin
                div_req.start = pairs_done && !r_eval_mode && !r_acc[AW-1]
                                && (r_acc != '0);
                div_req.num   = r_acc;
                div_req.den   = {{(SW-VW){1'b0}}, r_w};
            end
            default: div_req = '0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= nlc_pkg::S_IDLE;
            r_target_dim  <= '0;
            r_eval_mode   <= 1'b0;
            r_pair_count  <= '0;
            r_scale_count <= '0;
            r_sum         <= '0;
            r_ovf         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_state == nlc_pkg::S_EMIT);

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    nlc_pkg::CFG_TARGET_DIM: r_target_dim <= i_cfg_data;
                    nlc_pkg::CFG_EVAL_MODE:  r_eval_mode  <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // Loads
            if (accept && i_command == nlc_pkg::CMD_ROW && row_keep) begin
                if (r_pair_count == PCW'(DIAGRAM_DEPTH)) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_pair_count <= r_pair_count + 1'b1;
                    if (sum_next[SW] != sum_next[SW-1]) begin
                        r_sum <= sum_next[SW] ? {1'b1, {(SW-1){1'b0}}}
                                              : {1'b0, {(SW-1){1'b1}}};
                    end else begin
                        r_sum <= sum_next[SW-1:0];
                    end
                end
            end
            if (scale_we) begin
                r_scale_count <= r_scale_count + 1'b1;
            end

            // Empty stores after the final result
            if (r_state == nlc_pkg::S_EMIT && last_pt) begin
                r_pair_count  <= '0;
                r_scale_count <= '0;
                r_sum         <= '0;
                r_ovf         <= 1'b0;
            end
        end
    end

    // Compute datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            nlc_pkg::S_IDLE: begin
                r_k      <= '0;
                r_status <= r_ovf ? nlc_pkg::ST_OVF : nlc_pkg::ST_OK;
                if (r_eval_mode) begin
                    r_nres <= r_scale_count;
                end else begin
                    r_nres <= (r_scale_count != '0) ? r_scale_count - 1'b1 : '0;
                end
            end
            nlc_pkg::S_CHECK: begin
                r_value <= '0;
                if (r_nres == '0) begin
                    r_status <= nlc_pkg::ST_FEW;
                end
            end
            nlc_pkg::S_SCALE: begin
                r_lo       <= mem_s0;
                r_hi       <= mem_s1;
                r_w        <= w_now[VW-1:0];
                r_acc      <= '0;
                r_value    <= '0;
                r_pair_idx <= '0;
            end
            nlc_pkg::S_PAIR: begin
                r_c   <= clip[VW-1:0];
                r_neg <= pl[VW] ^ r_sum[SW-1];
                if (!pair_use) begin
                    r_pair_idx <= r_pair_idx + 1'b1;
                end
            end
            nlc_pkg::S_NDIV: begin
                if (div_rsp.done) begin
                    r_n <= n_sat;
                end
            end
            nlc_pkg::S_MUL: begin
                r_add <= r_eval_mode ? {{(AW-VW){r_n[VW-1]}}, r_n} : prod[AW-1:0];
            end
            nlc_pkg::S_ACC: begin
                if (acc_ovf) begin
                    r_acc <= r_acc[AW-1] ? {1'b1, {(AW-1){1'b0}}}
                                         : {1'b0, {(AW-1){1'b1}}};
                end else begin
                    r_acc <= acc_sum;
                end
                r_pair_idx <= r_pair_idx + 1'b1;
            end
            nlc_pkg::S_NEXT: begin
                if (pairs_done) begin
                    r_value <= r_eval_mode ? acc_clamp : '0;
                end
            end
            nlc_pkg::S_WDIV: begin
                if (div_rsp.done) begin
                    r_value <= q_clamp;
                end
            end
            nlc_pkg::S_EMIT: begin
                r_out_value  <= r_value;
                r_out_idx    <= nlc_pkg::PIDX_W'(r_k);
                r_out_last   <= last_pt;
                r_out_status <= r_status;
                r_k          <= r_k + 1'b1;
            end
            default: ;
        endcase
    end

    assign o_valid       = r_out_valid;
    assign o_curve_value = r_out_value;
    assign o_point_index = r_out_idx;
    assign o_last        = r_out_last;
    assign o_status      = r_out_status;

endmodule

[rtl/nlc_checker.sv]
`timescale 1ns / 1ps
`include "normalized_life_curve_macros.svh"

module nlc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_start,
    input logic                             o_busy,
    input logic [1:0]                       i_command,
    input logic                             o_valid,
    input logic [nlc_pkg::CURVE_W-1:0]      o_curve_value,
    input logic                             o_last,
    input logic [1:0]                       o_status
);

    // Compute beat holds the block busy
    `NLC_ASSERT_NXT(a_compute_busy, i_start && !o_busy && i_command == nlc_pkg::CMD_COMPUTE, o_busy)
    // Final result releases the block, earlier ones keep it busy
    `NLC_ASSERT_IMP(a_last_idle, o_valid && o_last, !o_busy)
    `NLC_ASSERT_IMP(a_mid_busy, o_valid && !o_last, o_busy)
    // Too-few-points result stands alone with a zero value
    `NLC_ASSERT_IMP(a_few_single, o_valid && o_status == nlc_pkg::ST_FEW, o_last && o_curve_value == '0)
    // Results never come in adjacent cycles
    `NLC_ASSERT_NXT(a_gap, o_valid, !o_valid)

endmodule

bind normalized_life_curve nlc_checker u_nlc_checker (.*);

[verif/normalized_life_curve_tb.sv]
`timescale 1ns / 1ps

module normalized_life_curve_tb;
    import nlc_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         STALL_LIMIT = 200000;
    localparam int         DIAG_CAP = 256;
    localparam int         SCALE_CAP = 64;
    localparam longint     SUM48_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint     SUM48_LO = -SUM48_HI - 1;
    localparam longint     CURVE_HI = 64'sh0000_00FF_FFFF_FFFF;
    localparam longint     S64_HI = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint     S64_LO = -S64_HI - 1;
    localparam int         TOTAL_BEATS = 420;

    typedef struct {
        logic [CURVE_W-1:0] curve;
        logic [PIDX_W-1:0]  idx;
        logic               last;
        logic [1:0]         status;
    } t_curve_pt;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic                    i_cfg_index;
    logic [DIM_W-1:0]        i_cfg_data;
    logic                    i_start;
    logic                    o_busy;
    logic [1:0]              i_command;
    logic [DIM_W-1:0]        i_row_dimension;
    logic signed [VAL_W-1:0] i_birth_value;
    logic signed [VAL_W-1:0] i_death_value;
    logic                    i_death_infinite;
    logic signed [VAL_W-1:0] i_scale_value;
    logic                    o_valid;
    logic [CURVE_W-1:0]      o_curve_value;
    logic [PIDX_W-1:0]       o_point_index;
    logic                    o_last;
    logic [1:0]              o_status;

    normalized_life_curve dut (.*);

    // Predictor state
    longint      birth_q[$];
    longint      death_q[$];
    longint      scale_q[$];
    longint      life_sum;
    bit          dropped_rows;
    logic [2:0]  keep_dim;
    bit          point_mode;
    t_curve_pt   expected_curve[$];

    int  errors;
    int  beats_sent;
    bit  gaps_on;
    int  quiet_cycles;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Normalized lifetime of pair i, Q16.16 saturated
    function automatic longint norm_life(int i);
        longint n;
        if (life_sum == 0) return 0;
        n = ((death_q[i] - birth_q[i]) * 65536) / life_sum;
        if (n > 64'sd2147483647) n = 64'sd2147483647;
        if (n < -64'sd2147483648) n = -64'sd2147483648;
        return n;
    endfunction

    function automatic longint add_sat64(longint a, longint b);
        longint r;
        r = a + b;
        if (a > 0 && b > 0 && r < 0) return S64_HI;
        if (a < 0 && b < 0 && r >= 0) return S64_LO;
        return r;
    endfunction

    // Build the expected curve and empty the stores
    task automatic predict_curve();
        int        nres;
        longint    acc, lo, hi, w, top, bot, c;
        t_curve_pt pt;
        nres = point_mode ? scale_q.size() : (scale_q.size() >= 1 ? scale_q.size() - 1 : 0);
        if (nres == 0) begin
            pt.curve = '0;
            pt.idx = '0;
            pt.last = 1'b1;
            pt.status = ST_FEW;
            expected_curve.push_back(pt);
        end
        for (int k = 0; k < nres; k++) begin
            acc = 0;
            if (point_mode) begin
                for (int i = 0; i < birth_q.size(); i++)
                    if (scale_q[k] >= birth_q[i] && scale_q[k] < death_q[i])
                        acc += norm_life(i);
            end else begin
                lo = scale_q[k];
                hi = scale_q[k+1];
                w = hi - lo;
                if (w > 0) begin
                    for (int i = 0; i < birth_q.size(); i++) begin
                        top = death_q[i] < hi ? death_q[i] : hi;
                        bot = birth_q[i] > lo ? birth_q[i] : lo;
                        c = top - bot;
                        if (c > 0) acc = add_sat64(acc, norm_life(i) * c);
                    end
                    acc = acc / w;
                end
            end
            if (acc < 0) acc = 0;
            if (acc > CURVE_HI) acc = CURVE_HI;
            pt.curve = acc[CURVE_W-1:0];
            pt.idx = k[PIDX_W-1:0];
            pt.last = (k + 1 == nres);
            pt.status = dropped_rows ? ST_OVF : ST_OK;
            expected_curve.push_back(pt);
        end
        birth_q.delete();
        death_q.delete();
        scale_q.delete();
        life_sum = 0;
        dropped_rows = 0;
    endtask

    task automatic predict_beat(logic [1:0] cmd, logic [2:0] dim, logic signed [31:0] b,
                                logic signed [31:0] d, logic inf, logic signed [31:0] s);
        longint sum;
        case (cmd)
            CMD_ROW: begin
                if (dim == keep_dim && !inf) begin
                    if (birth_q.size() >= DIAG_CAP) begin
                        dropped_rows = 1;
                    end else begin
                        birth_q.push_back(longint'(b));
                        death_q.push_back(longint'(d));
                        sum = life_sum + (longint'(d) - longint'(b));
                        if (sum > SUM48_HI) sum = SUM48_HI;
                        if (sum < SUM48_LO) sum = SUM48_LO;
                        life_sum = sum;
                    end
                end
            end
            CMD_SCALE: begin
                if (scale_q.size() < SCALE_CAP) scale_q.push_back(longint'(s));
            end
            CMD_COMPUTE: predict_curve();
            default: ;
        endcase
    endtask

    // Send one beat; returns at the edge that accepted it, start left high
    task automatic send_beat(logic [1:0] cmd, logic [2:0] dim, logic signed [31:0] b,
                             logic signed [31:0] d, logic inf, logic signed [31:0] s);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_command <= cmd;
        i_row_dimension <= dim;
        i_birth_value <= b;
        i_death_value <= d;
        i_death_infinite <= inf;
        i_scale_value <= s;
        i_start <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_busy) break;
        end
        predict_beat(cmd, dim, b, d, inf, s);
        beats_sent++;
    endtask

    task automatic load_row(logic [2:0] dim, logic signed [31:0] b, logic signed [31:0] d,
                            logic inf);
        send_beat(CMD_ROW, dim, b, d, inf, $urandom);
    endtask

    task automatic load_scale(logic signed [31:0] s);
        send_beat(CMD_SCALE, 3'($urandom), $urandom, $urandom, 1'($urandom), s);
    endtask

    task automatic run_compute();
        send_beat(CMD_COMPUTE, 3'($urandom), $urandom, $urandom, 1'($urandom), $urandom);
    endtask

    // Register write, only once all results are in and the block is idle
    task automatic write_reg(logic idx, logic [2:0] val);
        i_start <= 1'b0;
        @(posedge i_clk);
        while (expected_curve.size() != 0 || o_busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_TARGET_DIM) keep_dim = val;
        else point_mode = val[0];
    endtask

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'sh8000_0000 + $urandom_range(0, 3);
            2: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
        endcase
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_curve.size() == 0) begin
                $display("%0t: unexpected result curve=%h idx=%0d", $time, o_curve_value,
                         o_point_index);
                errors++;
            end else begin
                t_curve_pt exp_pt;
                exp_pt = expected_curve.pop_front();
                if (o_curve_value !== exp_pt.curve) begin
                    $display("%0t: curve_value exp %h got %h", $time, exp_pt.curve,
                             o_curve_value);
                    errors++;
                end
                if (o_point_index !== exp_pt.idx) begin
                    $display("%0t: point_index exp %0d got %0d", $time, exp_pt.idx,
                             o_point_index);
                    errors++;
                end
                if (o_last !== exp_pt.last) begin
                    $display("%0t: last exp %0d got %0d", $time, exp_pt.last, o_last);
                    errors++;
                end
                if (o_status !== exp_pt.status) begin
                    $display("%0t: status exp %0d got %0d", $time, exp_pt.status, o_status);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat moving either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("normalized_life_curve_tb NOT OK");
                $finish;
            end
        end
    end

    // Extremes, dropped rows, zero widths, both modes
    task automatic test_directed();
        write_reg(CFG_TARGET_DIM, 3'd0);
        write_reg(CFG_EVAL_MODE, 1'b0);
        load_row(3'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
        load_row(3'd0, 32'sh0001_0000, 32'sh0003_0000, 1'b0);
        load_row(3'd0, 32'sh0002_0000, 32'sh0002_0000, 1'b0);
        load_row(3'd0, 32'sh0004_0000, 32'sh0001_0000, 1'b0);
        load_row(3'd5, 32'sh0000_0000, 32'sh0005_0000, 1'b0);
        load_row(3'd0, 32'sh0000_0000, 32'sh0005_0000, 1'b1);
        load_scale(32'sh8000_0000);
        load_scale(32'sh0000_0000);
        load_scale(32'sh0000_0000);
        load_scale(32'sh0002_8000);
        load_scale(32'sh0001_0000);
        load_scale(32'sh7FFF_FFFF);
        run_compute();
        // empty diagram with points
        load_scale(32'sh0000_0000);
        load_scale(32'sh0001_0000);
        run_compute();
        // one point only in intervals mode
        load_row(3'd0, 32'sh0000_0000, 32'sh0001_0000, 1'b0);
        load_scale(32'sh0000_0000);
        run_compute();
        send_beat(CMD_UNUSED, 3'd0, 32'sd0, 32'sd0, 1'b0, 32'sd0);
        write_reg(CFG_EVAL_MODE, 1'b1);
        write_reg(CFG_TARGET_DIM, 3'd7);
        run_compute();
        load_row(3'd7, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
        load_row(3'd7, 32'sh0001_0000, 32'sh0002_0000, 1'b0);
        load_row(3'd7, 32'sh0003_0000, 32'sh0001_0000, 1'b0);
        load_scale(32'sh8000_0000);
        load_scale(32'sh0001_0000);
        load_scale(32'sh0002_0000);
        load_scale(32'sh7FFF_FFFF);
        run_compute();
    endtask

    // Diagram store overflow and scale store full
    task automatic test_store_limits();
        write_reg(CFG_EVAL_MODE, 1'b1);
        for (int i = 0; i < DIAG_CAP + 1; i++)
            load_row(3'd7, rand_q(), rand_q(), 1'b0);
        load_scale(rand_q());
        run_compute();
        load_row(3'd7, 32'sh0000_0000, 32'sh0020_0000, 1'b0);
        for (int i = 0; i < SCALE_CAP + 1; i++) load_scale(32'sh0000_1000 * i);
        run_compute();
    endtask

    // Random diagrams, mostly well formed and small
    task automatic test_random();
        int               npairs, nscales;
        logic signed [31:0] b, s;
        while (beats_sent < TOTAL_BEATS) begin
            gaps_on = beats_sent < TOTAL_BEATS - TOTAL_BEATS / 8;
            if ($urandom_range(0, 2) == 0) write_reg(CFG_TARGET_DIM, 3'($urandom));
            if ($urandom_range(0, 3) == 0) write_reg(CFG_EVAL_MODE, 1'($urandom));
            npairs = $urandom_range(0, 6);
            for (int i = 0; i < npairs; i++) begin
                if ($urandom_range(0, 5) == 0) begin
                    load_row(3'($urandom), rand_q(), rand_q(), 1'($urandom));
                end else begin
                    b = rand_q();
                    load_row(keep_dim, b,
                             $urandom_range(0, 3) == 0 ? rand_q()
                                 : b + $signed($urandom_range(0, 32'h0004_0000)), 1'b0);
                end
            end
            nscales = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : $urandom_range(2, 9);
            s = rand_q();
            for (int i = 0; i < nscales; i++) begin
                load_scale(s);
                case ($urandom_range(0, 7))
                    0: s = rand_q();
                    1: ;
                    default: s = s + $signed($urandom_range(1, 32'h0002_0000));
                endcase
            end
            if ($urandom_range(0, 7) == 0)
                send_beat(CMD_UNUSED, 3'($urandom), $urandom, $urandom, 1'($urandom), $urandom);
            run_compute();
        end
    endtask

    initial begin
        errors = 0;
        beats_sent = 0;
        gaps_on = 1;
        life_sum = 0;
        dropped_rows = 0;
        keep_dim = 3'd0;
        point_mode = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= 1'b0;
        i_cfg_data <= '0;
        i_start <= 1'b0;
        i_command <= CMD_ROW;
        i_row_dimension <= '0;
        i_birth_value <= '0;
        i_death_value <= '0;
        i_death_infinite <= 1'b0;
        i_scale_value <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_store_limits();
        test_random();

        i_start <= 1'b0;
        @(posedge i_clk);
        while (expected_curve.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("normalized_life_curve_tb OK");
        end else begin
            $display("normalized_life_curve_tb NOT OK");
        end
        $finish;
    end
endmodule
